// ===== rtl/core/arbm_pkg.sv =====
// ---------------------------------------------------------------------------
// arbm_pkg
// shared types, register indexes and constants of the affine box merger
// ---------------------------------------------------------------------------
package arbm_pkg;

   localparam int COORD_W  = 32;
   localparam int PROD_W   = 2 * COORD_W;
   localparam int Q_FRAC   = 16;
   localparam int CSR_AW   = 3;

   localparam logic signed [COORD_W-1:0] BOX_EMPTY_LO = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] BOX_EMPTY_HI = 32'sh8000_0000;

   localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh0001_0000;

   typedef enum logic [CSR_AW-1:0] {
      REG_MAT_XX  = 3'd0,
      REG_MAT_XY  = 3'd1,
      REG_MAT_YX  = 3'd2,
      REG_MAT_YY  = 3'd3,
      REG_SHIFT_X = 3'd4,
      REG_SHIFT_Y = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] mat_xx;
      logic signed [COORD_W-1:0] mat_xy;
      logic signed [COORD_W-1:0] mat_yx;
      logic signed [COORD_W-1:0] mat_yy;
      logic signed [COORD_W-1:0] shift_x;
      logic signed [COORD_W-1:0] shift_y;
   } csr_type;

   // rectangle or box, min and max corners
   typedef struct packed {
      logic signed [COORD_W-1:0] hi_y;
      logic signed [COORD_W-1:0] hi_x;
      logic signed [COORD_W-1:0] lo_y;
      logic signed [COORD_W-1:0] lo_x;
   } rect_type;

   // partial products, named by coefficient and source coordinate
   typedef struct packed {
      logic signed [PROD_W-1:0] xx_lo;
      logic signed [PROD_W-1:0] xx_hi;
      logic signed [PROD_W-1:0] yx_lo;
      logic signed [PROD_W-1:0] yx_hi;
      logic signed [PROD_W-1:0] xy_lo;
      logic signed [PROD_W-1:0] xy_hi;
      logic signed [PROD_W-1:0] yy_lo;
      logic signed [PROD_W-1:0] yy_hi;
      logic                     restart;
   } prod_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      point_type [3:0] pt;
      logic            restart;
   } corner_type;

   typedef struct packed {
      rect_type ext;
      logic     restart;
   } ext_type;

endpackage

// ===== rtl/core/arbm_csr.sv =====
// ---------------------------------------------------------------------------
// arbm_csr
// matrix and translation registers, write only
// ---------------------------------------------------------------------------
module arbm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [arbm_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [arbm_pkg::COORD_W-1:0]    csr_wdata,
   output arbm_pkg::csr_type               csr_o
);
   import arbm_pkg::*;

   csr_type regs_ff;
   csr_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         unique case (reg_idx_type'(csr_addr))
            REG_MAT_XX:  regs_in.mat_xx  = csr_wdata;
            REG_MAT_XY:  regs_in.mat_xy  = csr_wdata;
            REG_MAT_YX:  regs_in.mat_yx  = csr_wdata;
            REG_MAT_YY:  regs_in.mat_yy  = csr_wdata;
            REG_SHIFT_X: regs_in.shift_x = csr_wdata;
            REG_SHIFT_Y: regs_in.shift_y = csr_wdata;
            default:     regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.mat_xx  <= Q_ONE;
         regs_ff.mat_xy  <= '0;
         regs_ff.mat_yx  <= '0;
         regs_ff.mat_yy  <= Q_ONE;
         regs_ff.shift_x <= '0;
         regs_ff.shift_y <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_o = regs_ff;

endmodule

// ===== rtl/core/arbm_prod.sv =====
// ---------------------------------------------------------------------------
// arbm_prod
// first stage: the eight coefficient by coordinate products, registered
// ---------------------------------------------------------------------------
module arbm_prod (
   input  logic                 clock,
   input  logic                 reset,
   input  arbm_pkg::csr_type    csr_i,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  arbm_pkg::rect_type   rect_i,
   input  logic                 restart_i,
   output logic                 out_valid,
   input  logic                 out_ready,
   output arbm_pkg::prod_type   prod_o
);
   import arbm_pkg::*;

   logic     valid_ff;
   prod_type prod_ff;
   prod_type prod_in;

   always_comb begin
      prod_in.xx_lo   = csr_i.mat_xx * rect_i.lo_x;
      prod_in.xx_hi   = csr_i.mat_xx * rect_i.hi_x;
      prod_in.yx_lo   = csr_i.mat_yx * rect_i.lo_y;
      prod_in.yx_hi   = csr_i.mat_yx * rect_i.hi_y;
      prod_in.xy_lo   = csr_i.mat_xy * rect_i.lo_x;
      prod_in.xy_hi   = csr_i.mat_xy * rect_i.hi_x;
      prod_in.yy_lo   = csr_i.mat_yy * rect_i.lo_y;
      prod_in.yy_hi   = csr_i.mat_yy * rect_i.hi_y;
      prod_in.restart = restart_i;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod_o    = prod_ff;

endmodule

// ===== rtl/core/arbm_map.sv =====
// ---------------------------------------------------------------------------
// arbm_map
// second stage: sums products per corner, drops the fraction, adds the
// translation and saturates to 32 bits
// ---------------------------------------------------------------------------
module arbm_map (
   input  logic                 clock,
   input  logic                 reset,
   input  arbm_pkg::csr_type    csr_i,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  arbm_pkg::prod_type   prod_i,
   output logic                 out_valid,
   input  logic                 out_ready,
   output arbm_pkg::corner_type corner_o
);
   import arbm_pkg::*;

   localparam int SUM_W = PROD_W + 1;
   localparam int SHR_W = SUM_W - Q_FRAC;
   localparam int RES_W = SHR_W + 1;

   function automatic logic signed [COORD_W-1:0] map_coord(
      input logic signed [PROD_W-1:0]  p1,
      input logic signed [PROD_W-1:0]  p2,
      input logic signed [COORD_W-1:0] t
   );
      logic signed [SUM_W-1:0] sum;
      logic signed [RES_W-1:0] res;
      logic signed [COORD_W-1:0] val;
      sum = SUM_W'(p1) + SUM_W'(p2);
      res = RES_W'($signed(sum[SUM_W-1:Q_FRAC])) + RES_W'(t);
      if (res[RES_W-1:COORD_W-1] == '0 || res[RES_W-1:COORD_W-1] == '1) begin
         val = res[COORD_W-1:0];
      end else if (res[RES_W-1]) begin
         val = BOX_EMPTY_HI;
      end else begin
         val = BOX_EMPTY_LO;
      end
      return val;
   endfunction

   logic       valid_ff;
   corner_type corner_ff;
   corner_type corner_in;

   // corners: lo/lo, hi/lo, hi/hi, lo/hi
   always_comb begin
      corner_in.pt[0].x  = map_coord(prod_i.xx_lo, prod_i.yx_lo, csr_i.shift_x);
      corner_in.pt[0].y  = map_coord(prod_i.xy_lo, prod_i.yy_lo, csr_i.shift_y);
      corner_in.pt[1].x  = map_coord(prod_i.xx_hi, prod_i.yx_lo, csr_i.shift_x);
      corner_in.pt[1].y  = map_coord(prod_i.xy_hi, prod_i.yy_lo, csr_i.shift_y);
      corner_in.pt[2].x  = map_coord(prod_i.xx_hi, prod_i.yx_hi, csr_i.shift_x);
      corner_in.pt[2].y  = map_coord(prod_i.xy_hi, prod_i.yy_hi, csr_i.shift_y);
      corner_in.pt[3].x  = map_coord(prod_i.xx_lo, prod_i.yx_hi, csr_i.shift_x);
      corner_in.pt[3].y  = map_coord(prod_i.xy_lo, prod_i.yy_hi, csr_i.shift_y);
      corner_in.restart  = prod_i.restart;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         corner_ff <= corner_in;
      end
   end

   assign out_valid = valid_ff;
   assign corner_o  = corner_ff;

endmodule

// ===== rtl/core/arbm_ext.sv =====
// ---------------------------------------------------------------------------
// arbm_ext
// third stage: extent of the four mapped corners by a two level compare tree
// ---------------------------------------------------------------------------
module arbm_ext (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  arbm_pkg::corner_type corner_i,
   output logic                 out_valid,
   input  logic                 out_ready,
   output arbm_pkg::ext_type    ext_o
);
   import arbm_pkg::*;

   function automatic logic signed [COORD_W-1:0] smin(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [COORD_W-1:0] smax(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      return (a > b) ? a : b;
   endfunction

   logic    valid_ff;
   ext_type ext_ff;
   ext_type ext_in;

   always_comb begin
      ext_in.ext.lo_x = smin(smin(corner_i.pt[0].x, corner_i.pt[1].x),
                             smin(corner_i.pt[2].x, corner_i.pt[3].x));
      ext_in.ext.hi_x = smax(smax(corner_i.pt[0].x, corner_i.pt[1].x),
                             smax(corner_i.pt[2].x, corner_i.pt[3].x));
      ext_in.ext.lo_y = smin(smin(corner_i.pt[0].y, corner_i.pt[1].y),
                             smin(corner_i.pt[2].y, corner_i.pt[3].y));
      ext_in.ext.hi_y = smax(smax(corner_i.pt[0].y, corner_i.pt[1].y),
                             smax(corner_i.pt[2].y, corner_i.pt[3].y));
      ext_in.restart  = corner_i.restart;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ext_ff <= ext_in;
      end
   end

   assign out_valid = valid_ff;
   assign ext_o     = ext_ff;

endmodule

// ===== rtl/core/arbm_box.sv =====
// ---------------------------------------------------------------------------
// arbm_box
// stored bounding box; merges each extent and doubles as the result register
// ---------------------------------------------------------------------------
module arbm_box (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  arbm_pkg::ext_type    ext_i,
   output logic                 out_valid,
   input  logic                 out_ready,
   output arbm_pkg::rect_type   box_o
);
   import arbm_pkg::*;

   logic     valid_ff;
   rect_type box_ff;
   rect_type box_in;
   rect_type base;

   always_comb begin
      if (ext_i.restart) begin
         base.lo_x = BOX_EMPTY_LO;
         base.lo_y = BOX_EMPTY_LO;
         base.hi_x = BOX_EMPTY_HI;
         base.hi_y = BOX_EMPTY_HI;
      end else begin
         base = box_ff;
      end
      box_in.lo_x = (ext_i.ext.lo_x < base.lo_x) ? ext_i.ext.lo_x : base.lo_x;
      box_in.lo_y = (ext_i.ext.lo_y < base.lo_y) ? ext_i.ext.lo_y : base.lo_y;
      box_in.hi_x = (ext_i.ext.hi_x > base.hi_x) ? ext_i.ext.hi_x : base.hi_x;
      box_in.hi_y = (ext_i.ext.hi_y > base.hi_y) ? ext_i.ext.hi_y : base.hi_y;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         box_ff.lo_x <= BOX_EMPTY_LO;
         box_ff.lo_y <= BOX_EMPTY_LO;
         box_ff.hi_x <= BOX_EMPTY_HI;
         box_ff.hi_y <= BOX_EMPTY_HI;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (in_ready && in_valid) begin
            box_ff <= box_in;
         end
      end
   end

   assign out_valid = valid_ff;
   assign box_o     = box_ff;

endmodule

// ===== rtl/core/affine_rect_bounds_merge_top.sv =====
// ---------------------------------------------------------------------------
// affine_rect_bounds_merge_top
// maps rectangle corners through a 2x2 Q16.16 matrix plus translation and
// grows a stored bounding box by them
//
// req_ carries one rectangle per word, with a restart flag in req_tuser that
// empties the box before the merge. rsp_ returns the updated box, one word
// per rectangle, in order. csr_ writes the four coefficients and the two
// translations; write them only while no word is in flight.
// From req acceptance to rsp_tvalid a word passes through four registers:
// product register (loaded at the acceptance edge), corner map register,
// corner extent register, box register. One word is taken every cycle while
// rsp_ does not stall; the only loop is the compare and update of the box.
// Each stage holds while the next one is full and stalled, so an rsp stall
// backs up through the four registers and req_tready drops only once all of
// them hold words. Reset empties the pipeline, sets the box to empty (min at
// the largest value, max at the smallest) and loads the identity transform.
// ---------------------------------------------------------------------------
module affine_rect_bounds_merge_top (
   input  logic                              clock,
   input  logic                              reset,
   // lo_x, lo_y, hi_x, hi_y
   input  logic [4*arbm_pkg::COORD_W-1:0]    req_tdata,
   // restart
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // out_lo_x, out_lo_y, out_hi_x, out_hi_y
   output logic [4*arbm_pkg::COORD_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [arbm_pkg::CSR_AW-1:0]       csr_addr,
   input  logic [arbm_pkg::COORD_W-1:0]      csr_wdata
);
   import arbm_pkg::*;

   csr_type    csr;
   rect_type   rect;
   prod_type   prod;
   corner_type corner;
   ext_type    ext;
   rect_type   box;

   logic prod_valid, prod_ready;
   logic map_valid, map_ready;
   logic ext_valid, ext_ready;

   assign rect = rect_type'(req_tdata);

   arbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .csr_o     (csr)
   );

   arbm_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .csr_i     (csr),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .rect_i    (rect),
      .restart_i (req_tuser),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .prod_o    (prod)
   );

   arbm_map u_map (
      .clock     (clock),
      .reset     (reset),
      .csr_i     (csr),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .prod_i    (prod),
      .out_valid (map_valid),
      .out_ready (map_ready),
      .corner_o  (corner)
   );

   arbm_ext u_ext (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (map_valid),
      .in_ready  (map_ready),
      .corner_i  (corner),
      .out_valid (ext_valid),
      .out_ready (ext_ready),
      .ext_o     (ext)
   );

   arbm_box u_box (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ext_valid),
      .in_ready  (ext_ready),
      .ext_i     (ext),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .box_o     (box)
   );

   assign rsp_tdata = box;

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the affine rectangle bounds merger
//
// Rectangles go in on req_ and the grown box comes back on rsp_. A behavioral
// copy of the transform and the stored box predicts every box word. It covers
// the corner cases first: empty box without restart, inverted rectangles,
// saturation both ways and ignored register writes. It then runs random
// phases, each with its own transform written while the pipeline is drained.
// Both handshake sides idle at random, except in one phase that runs gap free.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import arbm_pkg::*;

   localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
   localparam logic [CSR_AW-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_AW-1:0] REG_SPARE_7 = 3'd7;
   localparam int IDLE_PCT    = 26;
   localparam int PIPE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      rect_type rect;
      logic     restart;
   } rect_word_type;

   logic                     clock;
   logic                     reset;
   logic [4*COORD_W-1:0]     req_tdata;   // lo_x, lo_y, hi_x, hi_y
   logic                     req_tuser;   // restart
   logic                     req_tvalid;
   logic                     req_tready;
   logic [4*COORD_W-1:0]     rsp_tdata;   // out_lo_x, out_lo_y, out_hi_x, out_hi_y
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_we;
   logic [CSR_AW-1:0]        csr_addr;
   logic [COORD_W-1:0]       csr_wdata;

   rect_word_type rect_backlog[$];
   rect_type   box_due[$];
   csr_type    xform;
   rect_type   box_now;
   logic       req_took;
   logic       no_gaps;
   int         mismatches;
   int         cycles;

   affine_rect_bounds_merge_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // floor((ca*va + cb*vb) / 2^16) + ofs, saturated
   function automatic logic signed [COORD_W-1:0] map_axis(
      input logic signed [COORD_W-1:0] ca, va, cb, vb, ofs);
      logic signed [65:0] a, b, c, d, t, sum, r;
      a = ca;
      b = va;
      c = cb;
      d = vb;
      t = ofs;
      sum = a * b + c * d;
      r = (sum >>> Q_FRAC) + t;
      if (r > SAT_HI) return Q_MAX;
      if (r < SAT_LO) return Q_MIN;
      return r[COORD_W-1:0];
   endfunction

   function automatic rect_type grow_box(input rect_type rect, input logic restart);
      logic signed [COORD_W-1:0] x, y, px, py;
      if (restart) begin
         box_now.lo_x = Q_MAX;
         box_now.lo_y = Q_MAX;
         box_now.hi_x = Q_MIN;
         box_now.hi_y = Q_MIN;
      end
      for (int c = 0; c < 4; c++) begin
         x = (c == 1 || c == 2) ? rect.hi_x : rect.lo_x;
         y = (c >= 2) ? rect.hi_y : rect.lo_y;
         px = map_axis(xform.mat_xx, x, xform.mat_yx, y, xform.shift_x);
         py = map_axis(xform.mat_xy, x, xform.mat_yy, y, xform.shift_y);
         if (px < box_now.lo_x) box_now.lo_x = px;
         if (px > box_now.hi_x) box_now.hi_x = px;
         if (py < box_now.lo_y) box_now.lo_y = py;
         if (py > box_now.hi_y) box_now.hi_y = py;
      end
      return box_now;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_q(input int unsigned span);
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 4))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               3: return -1;
               default: return Q_ONE;
            endcase
         end
         default: return $urandom_range(0, 2 * span) - span;
      endcase
   endfunction

   task automatic queue_rect(input logic signed [COORD_W-1:0] lx, ly, hx, hy,
                             input logic restart);
      rect_word_type w;
      w.rect.lo_x = lx;
      w.rect.lo_y = ly;
      w.rect.hi_x = hx;
      w.rect.hi_y = hy;
      w.restart = restart;
      rect_backlog.push_back(w);
   endtask

   task automatic set_reg(input logic [CSR_AW-1:0] idx, input logic [COORD_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         REG_MAT_XX:  xform.mat_xx = val;
         REG_MAT_XY:  xform.mat_xy = val;
         REG_MAT_YX:  xform.mat_yx = val;
         REG_MAT_YY:  xform.mat_yy = val;
         REG_SHIFT_X: xform.shift_x = val;
         REG_SHIFT_Y: xform.shift_y = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_xform(input logic [COORD_W-1:0] xx, xy, yx, yy, sx, sy);
      set_reg(REG_MAT_XX, xx);
      set_reg(REG_MAT_XY, xy);
      set_reg(REG_MAT_YX, yx);
      set_reg(REG_MAT_YY, yy);
      set_reg(REG_SHIFT_X, sx);
      set_reg(REG_SHIFT_Y, sy);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (rect_backlog.size() != 0 || req_tvalid || box_due.size() != 0);
      repeat (PIPE_CYCLES) @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      rect_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
         if (!req_tvalid || req_took) begin
            if (rect_backlog.size() != 0 &&
                (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
               w = rect_backlog.pop_front();
               req_tdata <= w.rect;
               req_tuser <= w.restart;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rect_type got, want;
      req_took = !reset && req_tvalid && req_tready;
      if (req_took) box_due.push_back(grow_box(rect_type'(req_tdata), req_tuser));
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (box_due.size() == 0) begin
            $error("box word with none expected: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = box_due.pop_front();
            if (got.lo_x !== want.lo_x) begin
               $error("out_lo_x: expected %0d, got %0d", want.lo_x, got.lo_x);
               mismatches++;
            end
            if (got.lo_y !== want.lo_y) begin
               $error("out_lo_y: expected %0d, got %0d", want.lo_y, got.lo_y);
               mismatches++;
            end
            if (got.hi_x !== want.hi_x) begin
               $error("out_hi_x: expected %0d, got %0d", want.hi_x, got.hi_x);
               mismatches++;
            end
            if (got.hi_y !== want.hi_y) begin
               $error("out_hi_y: expected %0d, got %0d", want.hi_y, got.hi_y);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic signed [COORD_W-1:0] a, b, c, d;
      reset = 1'b1;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tvalid = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      req_took = 1'b0;
      no_gaps = 1'b0;
      mismatches = 0;
      cycles = 0;
      xform.mat_xx = Q_ONE;
      xform.mat_xy = '0;
      xform.mat_yx = '0;
      xform.mat_yy = Q_ONE;
      xform.shift_x = '0;
      xform.shift_y = '0;
      box_now.lo_x = Q_MAX;
      box_now.lo_y = Q_MAX;
      box_now.hi_x = Q_MIN;
      box_now.hi_y = Q_MIN;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity transform out of reset, box starts empty with no restart
      queue_rect(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, 1'b0);
      queue_rect(32'sh0005_0000, 32'sh0006_0000, -32'sh0001_8000, -32'sh0000_4000, 1'b0);
      queue_rect(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
      queue_rect(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
      queue_rect(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 1'b1);
      queue_rect('0, '0, '0, '0, 1'b1);
      queue_rect(-1, -1, 1, 1, 1'b0);
      wait_drained();

      // extreme transform, out of range indexes are dropped
      set_xform(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
      set_reg(REG_SPARE_6, 32'h1234_5678);
      set_reg(REG_SPARE_7, '0);
      queue_rect(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 1'b1);
      queue_rect(Q_MAX, Q_MAX, Q_MIN, Q_MIN, 1'b1);
      queue_rect(-1, -1, 1, 1, 1'b1);
      queue_rect('0, '0, '0, '0, 1'b1);
      queue_rect(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1);
      wait_drained();

      set_xform(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX);
      queue_rect(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
      queue_rect(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
      queue_rect(Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1'b0);
      wait_drained();

      set_xform('0, '0, '0, '0, Q_MIN, Q_MAX);
      queue_rect(32'sh1234_5678, -32'sh0765_4321, Q_MAX, Q_MIN, 1'b1);
      queue_rect(Q_MAX, Q_MIN, 32'sh0000_0001, 32'sh0000_0002, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0)
            set_xform(Q_ONE, '0, '0, Q_ONE, '0, '0);
         else
            set_xform(rand_q(1 << 18), rand_q(1 << 18), rand_q(1 << 18),
                      rand_q(1 << 18), rand_q(1 << 26), rand_q(1 << 26));
         no_gaps <= (phase == 2);
         for (int n = 0; n < 250; n++) begin
            a = rand_q(1 << 26);
            b = rand_q(1 << 26);
            c = rand_q(1 << 26);
            d = rand_q(1 << 26);
            if ($urandom_range(0, 9) < 8)
               queue_rect((a < c) ? a : c, (b < d) ? b : d,
                          (a < c) ? c : a, (b < d) ? d : b,
                          $urandom_range(0, 7) == 0);
            else
               queue_rect(a, b, c, d, $urandom_range(0, 7) == 0);
         end
         wait_drained();
      end

      if (mismatches == 0 && box_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
